@@ rtl/thmj_pkg.sv @@
`default_nettype none

package thmj_pkg;

    localparam int COORD_BITS     = 21;
    localparam int REF_FRAC_BITS  = 14;
    localparam int REF_BITS       = 16;
    localparam int RESULT_BITS    = 32;
    localparam int REF_DIMS       = 3;
    localparam int NUM_AXES       = 3;
    localparam int NUM_CORNERS    = 2 ** REF_DIMS;
    localparam int CFG_DATA_BITS  = 63;
    localparam int CFG_INDEX_BITS = $clog2(NUM_CORNERS);
    localparam int CORNER_BITS    = NUM_AXES * COORD_BITS;

    // Exact intermediate widths of the Horner evaluation.
    localparam int COEF_BITS   = COORD_BITS + REF_DIMS;
    localparam int LIN_BITS    = COEF_BITS + REF_FRAC_BITS + 1;
    localparam int BILIN_BITS  = LIN_BITS + REF_FRAC_BITS + 1;
    localparam int TRILIN_BITS = BILIN_BITS + REF_FRAC_BITS + 1;

    localparam int POS_SHIFT = 3 * REF_FRAC_BITS + 3;
    localparam int JAC_SHIFT = 2 * REF_FRAC_BITS + 3;

    localparam logic signed [REF_BITS-1:0] REF_ONE = REF_BITS'(1 << REF_FRAC_BITS);

    localparam logic signed [RESULT_BITS-1:0] RESULT_MIN =
        $signed({1'b1, {(RESULT_BITS-1){1'b0}}});
    localparam logic signed [RESULT_BITS-1:0] RESULT_MAX = ~RESULT_MIN;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic signed [REF_BITS-1:0] ref_x;
        logic signed [REF_BITS-1:0] ref_y;
        logic signed [REF_BITS-1:0] ref_z;
    } ref_point_t;

    typedef struct packed {
        logic [1:0]                    axis;
        logic signed [RESULT_BITS-1:0] position;
        logic signed [RESULT_BITS-1:0] deriv_ref_x;
        logic signed [RESULT_BITS-1:0] deriv_ref_y;
        logic signed [RESULT_BITS-1:0] deriv_ref_z;
        logic                          in_range;
        logic                          last;
    } result_t;

    typedef struct packed {
        logic       valid;
        axis_t      axis;
        logic       in_range;
        logic       last;
        ref_point_t point;
    } slot_t;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t [NUM_CORNERS-1:0] coef_set_t;
    typedef coef_set_t [NUM_AXES-1:0] coef_bank_t;

    function automatic logic in_cube(input ref_point_t p);
        return ($signed(p.ref_x) >= -REF_ONE) && ($signed(p.ref_x) <= REF_ONE) &&
               ($signed(p.ref_y) >= -REF_ONE) && ($signed(p.ref_y) <= REF_ONE) &&
               ($signed(p.ref_z) >= -REF_ONE) && ($signed(p.ref_z) <= REF_ONE);
    endfunction

    function automatic logic signed [RESULT_BITS-1:0] sat_pos(
        input logic signed [TRILIN_BITS-1:0] v
    );
        logic signed [TRILIN_BITS-1:0] t;
        t = v >>> POS_SHIFT;
        if ((t[TRILIN_BITS-1:RESULT_BITS-1] == '0) || (t[TRILIN_BITS-1:RESULT_BITS-1] == '1))
            return $signed(t[RESULT_BITS-1:0]);
        else if (t[TRILIN_BITS-1])
            return RESULT_MIN;
        else
            return RESULT_MAX;
    endfunction

    function automatic logic signed [RESULT_BITS-1:0] sat_jac(
        input logic signed [BILIN_BITS-1:0] v
    );
        logic signed [BILIN_BITS-1:0] t;
        t = v >>> JAC_SHIFT;
        if ((t[BILIN_BITS-1:RESULT_BITS-1] == '0) || (t[BILIN_BITS-1:RESULT_BITS-1] == '1))
            return $signed(t[RESULT_BITS-1:0]);
        else if (t[BILIN_BITS-1])
            return RESULT_MIN;
        else
            return RESULT_MAX;
    endfunction

endpackage

`default_nettype wire

@@ rtl/thmj_coef.sv @@
`default_nettype none

module thmj_coef (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [thmj_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [thmj_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output thmj_pkg::coef_bank_t                     coef
);
    import thmj_pkg::*;

    logic [CORNER_BITS-1:0]      corner_reg [NUM_CORNERS];
    logic signed [COEF_BITS-1:0] bf [NUM_AXES][REF_DIMS+1][NUM_CORNERS];
    coef_bank_t                  coef_reg;
    coef_bank_t                  coef_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CORNERS; k++)
                corner_reg[k] <= '0;
        end
        else if (cfg_we)
        begin
            corner_reg[cfg_index] <= cfg_data[CORNER_BITS-1:0];
        end
    end

    // Each coefficient is a signed sum of corners, formed by a three-level butterfly.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int k = 0; k < NUM_CORNERS; k++)
                bf[a][0][k] = COEF_BITS'($signed(corner_reg[k][a*COORD_BITS +: COORD_BITS]));
            for (int d = 0; d < REF_DIMS; d++)
            begin
                for (int k = 0; k < NUM_CORNERS; k++)
                begin
                    if (((k >> d) & 1) != 0)
                        bf[a][d+1][k] = bf[a][d][k] - bf[a][d][k & ~(1 << d)];
                    else
                        bf[a][d+1][k] = bf[a][d][k] + bf[a][d][k | (1 << d)];
                end
            end
            for (int m = 0; m < NUM_CORNERS; m++)
                coef_next[a][m] = bf[a][REF_DIMS][m];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= '0;
        else
            coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

@@ rtl/thmj_issue.sv @@
`default_nettype none

module thmj_issue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 point_valid,
    output logic                      point_stall,
    input  wire thmj_pkg::ref_point_t point,
    input  wire logic                 slot_ready,
    output thmj_pkg::slot_t           slot
);
    import thmj_pkg::*;

    logic       hold_valid_reg;
    logic       hold_valid_next;
    axis_t      axis_reg;
    axis_t      axis_next;
    ref_point_t point_reg;
    ref_point_t point_next;
    logic       in_range_reg;
    logic       in_range_next;
    logic       accept;
    logic       slot_done;

    assign slot_done   = hold_valid_reg & slot_ready;
    assign point_stall = hold_valid_reg & ~(slot_ready & (axis_reg == AXIS_Z));
    assign accept      = point_valid & ~point_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        axis_next       = axis_reg;
        point_next      = point_reg;
        in_range_next   = in_range_reg;
        if (slot_done)
        begin
            case (axis_reg)
                AXIS_X: axis_next = AXIS_Y;
                AXIS_Y: axis_next = AXIS_Z;
                default:
                begin
                    hold_valid_next = 1'b0;
                    axis_next       = AXIS_X;
                end
            endcase
        end
        if (accept)
        begin
            hold_valid_next = 1'b1;
            axis_next       = AXIS_X;
            point_next      = point;
            in_range_next   = in_cube(point);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            axis_reg       <= AXIS_X;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            axis_reg       <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg    <= point_next;
        in_range_reg <= in_range_next;
    end

    always_comb
    begin
        slot.valid    = hold_valid_reg;
        slot.axis     = axis_reg;
        slot.in_range = in_range_reg;
        slot.last     = (axis_reg == AXIS_Z);
        slot.point    = point_reg;
    end

    a_accept_starts_x: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (hold_valid_reg && (axis_reg == AXIS_X)))
        else $error("accepted point does not start with the x axis");

endmodule

`default_nettype wire

@@ rtl/thmj_pipe.sv @@
`default_nettype none

module thmj_pipe (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire thmj_pkg::slot_t      slot,
    output logic                      slot_ready,
    input  wire thmj_pkg::coef_bank_t coef,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output thmj_pkg::result_t         result
);
    import thmj_pkg::*;

    typedef struct packed {
        logic [1:0] axis;
        logic       in_range;
        logic       last;
    } tag_t;

    logic en1;
    logic en2;
    logic en3;
    logic en_out;

    // Stage 1: products with zeta (and eta for the zeta derivative).
    coef_set_t                            cs;
    logic signed [COEF_BITS-1:0]          a [NUM_CORNERS];
    logic signed [REF_BITS+COEF_BITS-1:0] pz [4];
    logic signed [REF_BITS+COEF_BITS-1:0] pg [2];
    logic signed [LIN_BITS-1:0]           d1_next [4];
    logic signed [LIN_BITS-1:0]           g1_next [2];
    logic                                 v1_reg;
    tag_t                                 tag1_reg;
    logic signed [REF_BITS-1:0]           x1_reg;
    logic signed [REF_BITS-1:0]           y1_reg;
    logic signed [LIN_BITS-1:0]           d1_reg [4];
    logic signed [LIN_BITS-1:0]           g1_reg [2];

    // Stage 2: products with eta and xi, bilinear terms.
    logic signed [REF_BITS+LIN_BITS-1:0]  py [2];
    logic signed [REF_BITS+LIN_BITS-1:0]  px [2];
    logic signed [BILIN_BITS-1:0]         e0_next;
    logic signed [BILIN_BITS-1:0]         jx_next;
    logic signed [BILIN_BITS-1:0]         jy_next;
    logic signed [BILIN_BITS-1:0]         jz_next;
    logic                                 v2_reg;
    tag_t                                 tag2_reg;
    logic signed [REF_BITS-1:0]           x2_reg;
    logic signed [BILIN_BITS-1:0]         e0_reg;
    logic signed [BILIN_BITS-1:0]         jx2_reg;
    logic signed [BILIN_BITS-1:0]         jy2_reg;
    logic signed [BILIN_BITS-1:0]         jz2_reg;

    // Stage 3: final product with xi for the position.
    logic signed [REF_BITS+BILIN_BITS-1:0] ps;
    logic signed [TRILIN_BITS-1:0]         s_next;
    logic                                  v3_reg;
    tag_t                                  tag3_reg;
    logic signed [TRILIN_BITS-1:0]         s3_reg;
    logic signed [BILIN_BITS-1:0]          jx3_reg;
    logic signed [BILIN_BITS-1:0]          jy3_reg;
    logic signed [BILIN_BITS-1:0]          jz3_reg;

    // Output stage.
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;

    assign en_out     = ~result_valid_reg | ~result_stall;
    assign en3        = ~v3_reg | en_out;
    assign en2        = ~v2_reg | en3;
    assign en1        = ~v1_reg | en2;
    assign slot_ready = en1;

    always_comb
    begin
        cs = coef[slot.axis];
        for (int k = 0; k < NUM_CORNERS; k++)
            a[k] = $signed(cs[k]);
        for (int m = 0; m < 4; m++)
        begin
            pz[m]      = $signed(slot.point.ref_z) * a[m+4];
            d1_next[m] = (LIN_BITS'(a[m]) <<< REF_FRAC_BITS) + LIN_BITS'(pz[m]);
        end
        pg[0]      = $signed(slot.point.ref_y) * a[6];
        pg[1]      = $signed(slot.point.ref_y) * a[7];
        g1_next[0] = (LIN_BITS'(a[4]) <<< REF_FRAC_BITS) + LIN_BITS'(pg[0]);
        g1_next[1] = (LIN_BITS'(a[5]) <<< REF_FRAC_BITS) + LIN_BITS'(pg[1]);
    end

    always_comb
    begin
        py[0]   = y1_reg * d1_reg[2];
        py[1]   = y1_reg * d1_reg[3];
        px[0]   = x1_reg * d1_reg[3];
        px[1]   = x1_reg * g1_reg[1];
        e0_next = (BILIN_BITS'(d1_reg[0]) <<< REF_FRAC_BITS) + BILIN_BITS'(py[0]);
        jx_next = (BILIN_BITS'(d1_reg[1]) <<< REF_FRAC_BITS) + BILIN_BITS'(py[1]);
        jy_next = (BILIN_BITS'(d1_reg[2]) <<< REF_FRAC_BITS) + BILIN_BITS'(px[0]);
        jz_next = (BILIN_BITS'(g1_reg[0]) <<< REF_FRAC_BITS) + BILIN_BITS'(px[1]);
    end

    always_comb
    begin
        ps     = x2_reg * jx2_reg;
        s_next = (TRILIN_BITS'(e0_reg) <<< REF_FRAC_BITS) + TRILIN_BITS'(ps);
    end

    always_comb
    begin
        result_next.axis     = tag3_reg.axis;
        result_next.in_range = tag3_reg.in_range;
        result_next.last     = tag3_reg.last;
        if (tag3_reg.in_range)
        begin
            result_next.position    = sat_pos(s3_reg);
            result_next.deriv_ref_x = sat_jac(jx3_reg);
            result_next.deriv_ref_y = sat_jac(jy3_reg);
            result_next.deriv_ref_z = sat_jac(jz3_reg);
        end
        else
        begin
            result_next.position    = '0;
            result_next.deriv_ref_x = '0;
            result_next.deriv_ref_y = '0;
            result_next.deriv_ref_z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= slot.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en_out)
                result_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            tag1_reg.axis     <= slot.axis;
            tag1_reg.in_range <= slot.in_range;
            tag1_reg.last     <= slot.last;
            x1_reg            <= slot.point.ref_x;
            y1_reg            <= slot.point.ref_y;
            for (int m = 0; m < 4; m++)
                d1_reg[m] <= d1_next[m];
            for (int m = 0; m < 2; m++)
                g1_reg[m] <= g1_next[m];
        end
        if (en2)
        begin
            tag2_reg <= tag1_reg;
            x2_reg   <= x1_reg;
            e0_reg   <= e0_next;
            jx2_reg  <= jx_next;
            jy2_reg  <= jy_next;
            jz2_reg  <= jz_next;
        end
        if (en3)
        begin
            tag3_reg <= tag2_reg;
            s3_reg   <= s_next;
            jx3_reg  <= jx2_reg;
            jy3_reg  <= jy2_reg;
            jz3_reg  <= jz2_reg;
        end
        if (en_out)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_last_on_z: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.last == (result_reg.axis == AXIS_Z)))
        else $error("last flag does not match the z axis word");

    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.in_range) |->
            ((result_reg.position == '0) && (result_reg.deriv_ref_x == '0) &&
             (result_reg.deriv_ref_y == '0) && (result_reg.deriv_ref_z == '0)))
        else $error("point outside the cube gives nonzero values");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en_out) |=> (v3_reg && $stable(s3_reg) && $stable(tag3_reg)))
        else $error("stage 3 lost its word while the output was blocked");

endmodule

`default_nettype wire

@@ rtl/trilinear_hex_mapping_jacobian_top.sv @@
// Trilinear map of a hexahedron with its Jacobian. Eight corner registers define the
// element; a write takes effect for points accepted from the next cycle on, and corners
// should only be written while no point is in flight. Each accepted point yields three
// words, for the x, y and z axes in that order, each carrying the mapped coordinate and
// that row of the Jacobian. The arithmetic runs in four register stages behind an input
// holding register that issues one axis per cycle unless stalled; a new point is taken
// only when none is held or as the held point's z axis issues, a spacing set by the
// single shared multiply datapath that handles one axis at a time. Stalls on the output
// are absorbed stage by stage without loss.

`default_nettype none

module trilinear_hex_mapping_jacobian_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [thmj_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [thmj_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                point_valid,
    output logic                                     point_stall,
    input  wire thmj_pkg::ref_point_t                point,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output thmj_pkg::result_t                        result
);
    import thmj_pkg::*;

    coef_bank_t coef;
    slot_t      slot;
    logic       slot_ready;

    thmj_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    thmj_issue u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .slot_ready  (slot_ready),
        .slot        (slot)
    );

    thmj_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot         (slot),
        .slot_ready   (slot_ready),
        .coef         (coef),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ tb/tb_trilinear_hex_mapping_jacobian_top.sv @@
module tb_trilinear_hex_mapping_jacobian_top;
    timeunit 1ns;
    timeprecision 1ps;

    import thmj_pkg::*;

    typedef logic [CFG_DATA_BITS-1:0] corner_word_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [REF_BITS-1:0] ref_coord_t;

    localparam int     FINAL_SHIFT     = 2 * REF_FRAC_BITS + 3;
    localparam int     COORD_FRAC_BITS = 10;
    localparam longint COORD_ONE       = longint'(1) <<< COORD_FRAC_BITS;
    localparam longint COORD_MAX       = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN       = -(longint'(1) <<< (COORD_BITS - 1));
    localparam longint REF_UNIT        = longint'(1) <<< REF_FRAC_BITS;
    localparam int     IDLE_PCT        = 18;
    localparam int     SETTLE_CYCLES   = 8;

    class corner_map_scoreboard;
        coord_t  corner_coord [NUM_CORNERS][NUM_AXES];
        result_t pending_words [$];
        int      errors;

        function new();
            for (int k = 0; k < NUM_CORNERS; k++)
                for (int a = 0; a < NUM_AXES; a++)
                    corner_coord[k][a] = '0;
            errors = 0;
        endfunction

        function void set_corner(int k, corner_word_t w);
            for (int a = 0; a < NUM_AXES; a++)
                corner_coord[k][a] = w[a*COORD_BITS +: COORD_BITS];
        endfunction

        function logic signed [RESULT_BITS-1:0] sat_word(longint v);
            if (v > longint'(RESULT_MAX))
                return RESULT_MAX;
            if (v < longint'(RESULT_MIN))
                return RESULT_MIN;
            return RESULT_BITS'(v);
        endfunction

        // The trilinear weights are kept as exact integers and the low bits are
        // dropped only at the end, so every value rounds toward minus infinity.
        function void note_point(ref_point_t p);
            longint  r [REF_DIMS];
            longint  f [REF_DIMS];
            longint  g [REF_DIMS];
            longint  hi [NUM_AXES];
            longint  lo [NUM_AXES];
            longint  jac [NUM_AXES][REF_DIMS];
            longint  wt;
            longint  wh;
            longint  wl;
            longint  c;
            bit      point_ok;
            result_t w;

            r[0] = $signed(p.ref_x);
            r[1] = $signed(p.ref_y);
            r[2] = $signed(p.ref_z);
            point_ok = 1'b1;
            for (int d = 0; d < REF_DIMS; d++)
                if (r[d] < -REF_UNIT || r[d] > REF_UNIT)
                    point_ok = 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                hi[a] = 0;
                lo[a] = 0;
                for (int d = 0; d < REF_DIMS; d++)
                    jac[a][d] = 0;
            end
            if (point_ok)
            begin
                for (int k = 0; k < NUM_CORNERS; k++)
                begin
                    for (int d = 0; d < REF_DIMS; d++)
                    begin
                        f[d] = ((k >> d) & 1) ? REF_UNIT + r[d] : REF_UNIT - r[d];
                        g[d] = ((k >> d) & 1) ? 1 : -1;
                    end
                    wt = f[0] * f[1] * f[2];
                    wh = wt >>> REF_FRAC_BITS;
                    wl = wt & (REF_UNIT - 1);
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        c = corner_coord[k][a];
                        hi[a] += c * wh;
                        lo[a] += c * wl;
                        jac[a][0] += g[0] * c * (f[1] * f[2]);
                        jac[a][1] += g[1] * c * (f[0] * f[2]);
                        jac[a][2] += g[2] * c * (f[0] * f[1]);
                    end
                end
            end
            for (int a = 0; a < NUM_AXES; a++)
            begin
                w.axis     = axis_t'(a);
                w.in_range = point_ok;
                w.last     = (axis_t'(a) == AXIS_Z);
                if (point_ok)
                begin
                    w.position    = sat_word((hi[a] + (lo[a] >>> REF_FRAC_BITS)) >>> FINAL_SHIFT);
                    w.deriv_ref_x = sat_word(jac[a][0] >>> FINAL_SHIFT);
                    w.deriv_ref_y = sat_word(jac[a][1] >>> FINAL_SHIFT);
                    w.deriv_ref_z = sat_word(jac[a][2] >>> FINAL_SHIFT);
                end
                else
                begin
                    w.position    = '0;
                    w.deriv_ref_x = '0;
                    w.deriv_ref_y = '0;
                    w.deriv_ref_z = '0;
                end
                pending_words.push_back(w);
            end
        endfunction

        function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word: axis %0d, position %0d", got.axis, got.position);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            compare("axis", want.axis, got.axis);
            compare("position", want.position, got.position);
            compare("deriv_ref_x", want.deriv_ref_x, got.deriv_ref_x);
            compare("deriv_ref_y", want.deriv_ref_y, got.deriv_ref_y);
            compare("deriv_ref_z", want.deriv_ref_z, got.deriv_ref_z);
            compare("in_range", want.in_range, got.in_range);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    corner_word_t              cfg_data;
    logic                      point_valid;
    logic                      point_stall;
    ref_point_t                point;
    logic                      result_valid;
    logic                      result_stall;
    result_t                   result;

    int                   point_idle_pct = IDLE_PCT;
    int                   stall_pct = IDLE_PCT;
    corner_word_t         corner_set [NUM_CORNERS];
    corner_map_scoreboard sb = new;

    trilinear_hex_mapping_jacobian_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
        result_stall <= rst_n && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_word(result);

    function automatic corner_word_t pack_corner(longint x, longint y, longint z);
        return {COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)};
    endfunction

    // Each coordinate takes the high value at the plus end of its own reference axis.
    function automatic void set_cube(longint low_v, longint high_v);
        for (int k = 0; k < NUM_CORNERS; k++)
            corner_set[k] = pack_corner(((k >> 0) & 1) ? high_v : low_v,
                                        ((k >> 1) & 1) ? high_v : low_v,
                                        ((k >> 2) & 1) ? high_v : low_v);
    endfunction

    function automatic ref_point_t make_point(longint x, longint y, longint z);
        ref_point_t p;
        p.ref_x = REF_BITS'(x);
        p.ref_y = REF_BITS'(y);
        p.ref_z = REF_BITS'(z);
        return p;
    endfunction

    function automatic ref_coord_t rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return REF_BITS'(longint'($urandom_range(2 * REF_UNIT)) - REF_UNIT);
        if (pick < 85)
        begin
            case ($urandom_range(5))
                0: return REF_BITS'(-REF_UNIT);
                1: return REF_BITS'(REF_UNIT);
                2: return REF_BITS'(REF_UNIT - 1);
                3: return REF_BITS'(1 - REF_UNIT);
                4: return REF_BITS'(REF_UNIT + 1);
                default: return REF_BITS'(-REF_UNIT - 1);
            endcase
        end
        return REF_BITS'($urandom);
    endfunction

    function automatic ref_point_t rand_point();
        ref_point_t p;
        p.ref_x = rand_coord();
        p.ref_y = rand_coord();
        p.ref_z = rand_coord();
        return p;
    endfunction

    task automatic load_corners();
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_BITS'(k);
            cfg_data  <= corner_set[k];
            @(posedge clk);
            sb.set_corner(k, corner_set[k]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_point(input ref_point_t p);
        if ($urandom_range(99) < point_idle_pct)
        begin
            point_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < point_idle_pct);
        end
        point_valid <= 1'b1;
        point       <= p;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        sb.note_point(p);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_point(rand_point());
    endtask

    task automatic drain();
        point_valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        point_valid  = 1'b0;
        point        = '0;
        result_stall = 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All corners still at their reset value of zero.
        send_point(make_point(0, 0, 0));
        send_point(make_point(REF_UNIT, REF_UNIT, REF_UNIT));
        send_point(make_point(-REF_UNIT - 1, 0, 0));
        run_random(10);
        drain();

        set_cube(-COORD_ONE, COORD_ONE);
        load_corners();
        for (int k = 0; k < NUM_CORNERS; k++)
            send_point(make_point(((k >> 0) & 1) ? REF_UNIT : -REF_UNIT,
                                  ((k >> 1) & 1) ? REF_UNIT : -REF_UNIT,
                                  ((k >> 2) & 1) ? REF_UNIT : -REF_UNIT));
        send_point(make_point(0, 0, 0));
        send_point(make_point(REF_UNIT / 2, -REF_UNIT / 2, REF_UNIT / 4));
        send_point(make_point(REF_UNIT - 1, 1 - REF_UNIT, 1));
        send_point(make_point(REF_UNIT + 1, 0, 0));
        send_point(make_point(0, -REF_UNIT - 1, 0));
        send_point(make_point(0, 0, 32767));
        send_point(make_point(-32768, -32768, -32768));
        send_point(make_point(32767, 32767, 32767));
        run_random(40);
        drain();

        point_idle_pct = 0;
        stall_pct      = 0;
        set_cube(COORD_MAX, COORD_MAX);
        load_corners();
        run_random(50);
        drain();
        point_idle_pct = IDLE_PCT;
        stall_pct      = IDLE_PCT;

        set_cube(COORD_MIN, COORD_MIN);
        load_corners();
        run_random(50);
        drain();

        set_cube(COORD_MIN, COORD_MAX);
        load_corners();
        run_random(50);
        drain();

        set_cube(COORD_MAX, COORD_MIN);
        load_corners();
        run_random(30);
        drain();

        repeat (4)
        begin
            for (int k = 0; k < NUM_CORNERS; k++)
                corner_set[k] = corner_word_t'({$urandom, $urandom});
            load_corners();
            run_random(30);
            drain();
        end

        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("trilinear_hex_mapping_jacobian_top test passed");
        else
            $display("trilinear_hex_mapping_jacobian_top test failed");
        $finish;
    end

    initial
    begin
        #500_000;
        $display("trilinear_hex_mapping_jacobian_top test failed");
        $finish;
    end

endmodule
